FILE: hw/rtl/dfe_pkg.sv
`timescale 1ns / 1ps

package dfe_pkg;

    localparam int CHAR_W    = 8;
    localparam int LEN_W     = 4;
    localparam int COL_W     = 8;
    localparam int SINCE_W   = 4;
    localparam int SEPB_W    = 64;
    localparam int CFG_IDX_W = 2;

    localparam logic [SINCE_W-1:0] SINCE_MAX = 4'd15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_INDEX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_BYTES  = 2'd2;

    localparam logic [COL_W-1:0]  COLUMN_INDEX_RST     = 8'd1;
    localparam logic [LEN_W-1:0]  SEPARATOR_LENGTH_RST = 4'd1;
    localparam logic [SEPB_W-1:0] SEPARATOR_BYTES_RST  = 64'd44;

    typedef struct packed {
        logic [CHAR_W-1:0] char_out;
        logic              final_byte;
        logic              field_empty;
    } result_t;

    typedef struct packed {
        logic shift;   // take the right neighbor's byte
        logic load;    // take the incoming byte
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/delimited_field_extractor.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake          | Payload
// s_       | in  | s_tvalid/s_tready  | s_tdata = char_in, s_tlast = end_of_string
// m_       | out | m_tvalid/m_tready  | m_tdata = char_out, m_tlast = final_byte,
//          |     |                    | m_tuser = field_empty
// cfg_     | in  | cfg_valid/cfg_ready| cfg_index = register index, cfg_data = value
//
// One byte per cycle in steady state: an input register feeds a window of
// MAX_SEPARATOR cells that shift and compare against the separator in parallel.
// After a string's final byte, held bytes are released in turn before a closing step.
// A shortened separator length releases surplus held bytes one per cycle first.
// Synchronous active-low reset clears control state and loads register defaults.
// Output stalls fill a two-entry result queue; input keeps flowing until it is full.

module delimited_field_extractor
    import dfe_pkg::*;
#(
    parameter int MAX_SEPARATOR = 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] char_in
    input  logic                 s_tlast,
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,   // [7:0] char_out
    output logic                 m_tlast,
    output logic                 m_tuser,   // [0] field_empty
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEPB_W-1:0]    cfg_data
);

    localparam int HCW = $clog2(MAX_SEPARATOR + 1);

    typedef enum logic {
        ST_RUN,
        ST_FLUSH
    } state_t;

    // configuration
    logic [COL_W-1:0]  col_idx_reg;
    logic [LEN_W-1:0]  sep_len_reg;
    logic [SEPB_W-1:0] sep_bytes_reg;

    // input holding register
    logic              in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0] in_char_reg, in_char_next;
    logic              in_last_reg, in_last_next;

    // string state
    state_t            state_reg, state_next;
    logic [HCW-1:0]    held_reg, held_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [SINCE_W-1:0] since_reg, since_next;
    logic              emitted_reg, emitted_next;

    // staged result of the final step; it takes the last flag at close
    logic              stg_valid_reg, stg_valid_next;
    logic [CHAR_W-1:0] stg_char_reg, stg_char_next;

    // window cells
    logic [CHAR_W-1:0] cell_byte [MAX_SEPARATOR];
    logic              cell_hit  [MAX_SEPARATOR];
    cell_ctrl_t        cell_ctrl [MAX_SEPARATOR];

    logic              shift_en;
    logic              load_en;
    logic [HCW-1:0]    load_pos;

    logic [LEN_W-1:0]  eff_len;
    logic [LEN_W-1:0]  len_m1;
    logic [LEN_W-1:0]  held_ext;
    logic [CHAR_W-1:0] sep_last;
    logic              window_ok;
    logic              match;
    logic              col_sel;
    logic              space;
    logic              consume;

    logic              emit_valid;
    logic [CHAR_W-1:0] emit_byte;
    logic              emit_staged;
    logic              close;
    logic              push_valid;
    result_t           push_data;
    result_t           out_data;

    // ---------------------------------------------------------------
    // Separator length and compare
    // ---------------------------------------------------------------
    always_comb begin
        if (sep_len_reg == '0) begin
            eff_len = LEN_W'(1);
        end else if (sep_len_reg > LEN_W'(MAX_SEPARATOR)) begin
            eff_len = LEN_W'(MAX_SEPARATOR);
        end else begin
            eff_len = sep_len_reg;
        end
    end

    assign len_m1   = eff_len - LEN_W'(1);
    assign held_ext = LEN_W'(held_reg);
    assign sep_last = sep_bytes_reg[{len_m1[2:0], 3'b000} +: CHAR_W];
    assign col_sel  = (col_idx_reg != '0) && (cur_col_reg == col_idx_reg);

    // every held byte must sit on its separator position
    always_comb begin
        window_ok = 1'b1;
        for (int i = 0; i < MAX_SEPARATOR; i++) begin
            if (LEN_W'(i) < held_ext && !cell_hit[i]) begin
                window_ok = 1'b0;
            end
        end
    end

    // a match may only start at or after the end of the previous one
    assign match = (held_ext + LEN_W'(1) == eff_len) &&
                   (since_reg >= len_m1) &&
                   (in_char_reg == sep_last) && window_ok;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next     = state_reg;
        held_next      = held_reg;
        cur_col_next   = cur_col_reg;
        since_next     = since_reg;
        emitted_next   = emitted_reg;
        stg_valid_next = stg_valid_reg;
        stg_char_next  = stg_char_reg;

        shift_en    = 1'b0;
        load_en     = 1'b0;
        load_pos    = held_reg;
        consume     = 1'b0;
        emit_valid  = 1'b0;
        emit_byte   = cell_byte[0];
        emit_staged = in_last_reg;
        close       = 1'b0;

        unique case (state_reg)
            ST_RUN: begin
                if (in_valid_reg && space) begin
                    if (held_ext >= eff_len) begin
                        // release surplus bytes after a shorter separator was set
                        shift_en   = 1'b1;
                        held_next  = held_reg - HCW'(1);
                        emit_valid = col_sel;
                    end else begin
                        consume = 1'b1;
                        if (since_reg < SINCE_MAX) begin
                            since_next = since_reg + SINCE_W'(1);
                        end
                        if (match) begin
                            held_next  = '0;
                            since_next = '0;
                            if (cur_col_reg != '0) begin
                                cur_col_next = cur_col_reg + COL_W'(1);
                            end
                        end else if (held_ext + LEN_W'(1) == eff_len) begin
                            // window full: append and release the oldest byte
                            shift_en   = 1'b1;
                            load_en    = (held_reg != '0);
                            load_pos   = held_reg - HCW'(1);
                            emit_valid = col_sel;
                            emit_byte  = (held_reg == '0) ? in_char_reg : cell_byte[0];
                        end else begin
                            load_en   = 1'b1;
                            held_next = held_reg + HCW'(1);
                        end
                        if (in_last_reg) begin
                            state_next = ST_FLUSH;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                emit_staged = 1'b1;
                if (space) begin
                    if (held_reg != '0) begin
                        shift_en   = 1'b1;
                        held_next  = held_reg - HCW'(1);
                        emit_valid = col_sel;
                    end else begin
                        close          = 1'b1;
                        state_next     = ST_RUN;
                        held_next      = '0;
                        cur_col_next   = COL_W'(1);
                        since_next     = SINCE_MAX;
                        emitted_next   = 1'b0;
                        stg_valid_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_RUN;
            end
        endcase

        // route results: direct, or through the stage during a final step
        push_valid = 1'b0;
        push_data  = '{char_out: stg_char_reg, final_byte: 1'b0, field_empty: 1'b0};
        if (close) begin
            push_valid = 1'b1;
            if (stg_valid_reg) begin
                push_data = '{char_out: stg_char_reg, final_byte: 1'b1, field_empty: 1'b0};
            end else begin
                push_data = '{char_out: '0, final_byte: 1'b1, field_empty: !emitted_reg};
            end
        end else if (emit_valid) begin
            emitted_next = 1'b1;
            if (emit_staged) begin
                push_valid     = stg_valid_reg;
                stg_valid_next = 1'b1;
                stg_char_next  = emit_byte;
            end else begin
                push_valid = 1'b1;
                push_data  = '{char_out: emit_byte, final_byte: 1'b0, field_empty: 1'b0};
            end
        end
    end

    // ---------------------------------------------------------------
    // Input register
    // ---------------------------------------------------------------
    assign s_tready = !in_valid_reg || consume;

    always_comb begin
        in_valid_next = in_valid_reg && !consume;
        in_char_next  = in_char_reg;
        in_last_next  = in_last_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
            in_char_next  = s_tdata;
            in_last_next  = s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_idx_reg   <= COLUMN_INDEX_RST;
            sep_len_reg   <= SEPARATOR_LENGTH_RST;
            sep_bytes_reg <= SEPARATOR_BYTES_RST;
            in_valid_reg  <= 1'b0;
            state_reg     <= ST_RUN;
            held_reg      <= '0;
            cur_col_reg   <= COL_W'(1);
            since_reg     <= SINCE_MAX;
            emitted_reg   <= 1'b0;
            stg_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_COLUMN_INDEX:     col_idx_reg   <= cfg_data[COL_W-1:0];
                    REG_SEPARATOR_LENGTH: sep_len_reg   <= cfg_data[LEN_W-1:0];
                    REG_SEPARATOR_BYTES:  sep_bytes_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            in_valid_reg  <= in_valid_next;
            state_reg     <= state_next;
            held_reg      <= held_next;
            cur_col_reg   <= cur_col_next;
            since_reg     <= since_next;
            emitted_reg   <= emitted_next;
            stg_valid_reg <= stg_valid_next;
        end
        in_char_reg  <= in_char_next;
        in_last_reg  <= in_last_next;
        stg_char_reg <= stg_char_next;
    end

    // ---------------------------------------------------------------
    // Window cells: each holds one byte and compares it to its separator byte
    // ---------------------------------------------------------------
    for (genvar i = 0; i < MAX_SEPARATOR; i++) begin : g_cell
        logic [CHAR_W-1:0] right_byte;

        if (i == MAX_SEPARATOR - 1) begin : g_end
            assign right_byte = '0;
        end else begin : g_mid
            assign right_byte = cell_byte[i+1];
        end

        assign cell_ctrl[i].shift = shift_en;
        assign cell_ctrl[i].load  = load_en && (load_pos == HCW'(i));

        dfe_cell u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .load_byte  (in_char_reg),
            .right_byte (right_byte),
            .sep_byte   (sep_bytes_reg[CHAR_W*i +: CHAR_W]),
            .held_byte  (cell_byte[i]),
            .sep_hit    (cell_hit[i])
        );
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    dfe_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_data  (push_data),
        .has_space  (space),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_data   (out_data)
    );

    assign m_tdata = out_data.char_out;
    assign m_tlast = out_data.final_byte;
    assign m_tuser = out_data.field_empty;

endmodule

FILE: hw/rtl/dfe_cell.sv
`timescale 1ns / 1ps

module dfe_cell
    import dfe_pkg::*;
(
    input  logic              aclk,
    input  cell_ctrl_t        ctrl,
    input  logic [CHAR_W-1:0] load_byte,
    input  logic [CHAR_W-1:0] right_byte,
    input  logic [CHAR_W-1:0] sep_byte,
    output logic [CHAR_W-1:0] held_byte,
    output logic              sep_hit
);

    logic [CHAR_W-1:0] byte_reg;
    logic [CHAR_W-1:0] byte_next;

    always_comb begin
        if (ctrl.load) begin
            byte_next = load_byte;
        end else if (ctrl.shift) begin
            byte_next = right_byte;
        end else begin
            byte_next = byte_reg;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign held_byte = byte_reg;
    assign sep_hit   = (byte_reg == sep_byte);

endmodule

FILE: hw/rtl/dfe_out_fifo.sv
`timescale 1ns / 1ps

module dfe_out_fifo
    import dfe_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push_valid,
    input  result_t push_data,
    output logic    has_space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    result_t    head_reg;
    result_t    head_next;
    result_t    tail_reg;
    result_t    tail_next;
    logic       pop;
    logic [1:0] wr_pos;

    assign pop    = (count_reg != 2'd0) && out_ready;
    assign wr_pos = count_reg - {1'b0, pop};

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg + {1'b0, push_valid} - {1'b0, pop};
        if (pop) begin
            head_next = tail_reg;
        end
        if (push_valid) begin
            if (wr_pos == 2'd0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

    assign has_space = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = head_reg;

endmodule

FILE: hw/rtl/dfe_checker.sv
`timescale 1ns / 1ps

module dfe_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable({m_tdata, m_tlast, m_tuser}))
        else $error("stalled result changed");

    // an empty-field result is always the closing one and carries no byte
    a_empty_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == 8'd0))
        else $error("empty flag on a non-closing or nonzero result");

    // reset drains the result queue
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // reset empties the input register
    a_reset_in: assert property (@(posedge aclk)
        !aresetn |=> s_tready)
        else $error("input not ready right after reset");

endmodule

bind delimited_field_extractor dfe_checker u_dfe_checker (.*);

FILE: tb/delimited_field_extractor_tb.sv
`timescale 1ns / 1ps

module delimited_field_extractor_tb;
    import dfe_pkg::*;

    localparam int MAX_SEP        = 8;
    localparam int LONG_HOLD_CYCS = 400;
    localparam int SETTLE_CYCS    = 24;

    typedef struct {
        logic [7:0] ch;
        logic       eos;
    } char_item_t;

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals (all inputs known from time zero)
    // ------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_COLUMN_INDEX;
    logic [SEPB_W-1:0]    cfg_data  = '0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    delimited_field_extractor #(
        .MAX_SEPARATOR(MAX_SEP)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [7:0] char_in
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [7:0] char_out
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),   // [0] field_empty
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------
    char_item_t outgoing_chars[$];        // bytes waiting to be offered
    result_t    expected_column_bytes[$]; // predicted result transfers, oldest first
    int         mismatch_count    = 0;
    bit         calm              = 1'b0; // no idling on either side
    bit         hold_results_req  = 1'b0; // ask the receiver for one long hold-off

    // Predictor copy of the configuration registers
    logic [COL_W-1:0]  col_sel     = COLUMN_INDEX_RST;
    logic [LEN_W-1:0]  sep_len     = SEPARATOR_LENGTH_RST;
    logic [SEPB_W-1:0] sep_pattern = SEPARATOR_BYTES_RST;

    // Predictor copy of the per-string state
    logic [7:0] win_bytes[MAX_SEP];
    int         win_fill  = 0;
    int         col_now   = 1;   // 0 means past column 255
    int         since_sep = int'(SINCE_MAX);
    bit         sent_any  = 1'b0;

    // ------------------------------------------------------------------
    // Field extraction predictor
    // ------------------------------------------------------------------
    function automatic int eff_sep_len();
        int l;
        l = int'(sep_len);
        if (l == 0) l = 1;
        if (l > MAX_SEP) l = MAX_SEP;
        return l;
    endfunction

    function automatic void clear_string();
        foreach (win_bytes[i]) win_bytes[i] = 8'h00;
        win_fill  = 0;
        col_now   = 1;
        since_sep = int'(SINCE_MAX);
        sent_any  = 1'b0;
    endfunction

    // Drop the oldest held byte out of the window; pass it on if its column is selected.
    function automatic void release_held();
        logic [7:0] b;
        b = win_bytes[0];
        for (int i = 1; i < win_fill; i++) win_bytes[i-1] = win_bytes[i];
        if (win_fill > 0) win_fill--;
        if (col_sel != 0 && col_now == int'(col_sel)) begin
            expected_column_bytes.push_back('{char_out: b, final_byte: 1'b0,
                                              field_empty: 1'b0});
            sent_any = 1'b1;
        end
    endfunction

    function automatic void predict_extract(logic [7:0] c, logic eos);
        int      len;
        int      n0;
        bit      hit;
        result_t tail;
        len = eff_sep_len();
        n0  = expected_column_bytes.size();
        // A shortened separator leaves surplus bytes in the window: release them first.
        while (win_fill + 1 > len) release_held();
        hit = 1'b0;
        // Only test for a separator when the window is full and it cannot overlap the last one.
        if (win_fill + 1 == len && since_sep + 1 >= len) begin
            hit = (c == sep_pattern[8*(len-1) +: 8]);
            for (int i = 0; i < win_fill; i++)
                if (win_bytes[i] != sep_pattern[8*i +: 8]) hit = 1'b0;
        end
        if (since_sep < int'(SINCE_MAX)) since_sep++;
        if (hit) begin
            win_fill  = 0;
            since_sep = 0;
            if (col_now != 0) col_now = (col_now == 255) ? 0 : col_now + 1;
        end else begin
            if (win_fill < MAX_SEP) begin
                win_bytes[win_fill] = c;
                win_fill++;
            end
            if (win_fill >= len) release_held();
        end
        if (eos) begin
            // Flush the window, then mark the end of the string on the last transfer.
            while (win_fill > 0) release_held();
            if (!sent_any) begin
                expected_column_bytes.push_back('{char_out: 8'h00, final_byte: 1'b1,
                                                  field_empty: 1'b1});
            end else if (expected_column_bytes.size() == n0) begin
                expected_column_bytes.push_back('{char_out: 8'h00, final_byte: 1'b1,
                                                  field_empty: 1'b0});
            end else begin
                tail = expected_column_bytes.pop_back();
                tail.final_byte = 1'b1;
                expected_column_bytes.push_back(tail);
            end
            clear_string();
        end
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offer queued bytes, with random idle bursts
    // ------------------------------------------------------------------
    int         send_gap = 0;
    char_item_t next_char;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
            send_gap = 0;
        end else if (!s_tvalid || s_tready) begin
            // Current byte (if any) transfers at this edge; pick what to show next.
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                send_gap = $urandom_range(1, 11) - 1;
                s_tvalid <= 1'b0;
            end else if (outgoing_chars.size() > 0) begin
                next_char = outgoing_chars.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= next_char.ch;
                s_tlast  <= next_char.eos;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls plus one long hold-off on request
    // ------------------------------------------------------------------
    int recv_stall = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end else if (hold_results_req) begin
            hold_results_req = 1'b0;
            recv_stall = LONG_HOLD_CYCS - 1;
            m_tready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            recv_stall = $urandom_range(1, 11) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: track config writes, predict on input transfers, check results
    // ------------------------------------------------------------------
    task automatic note_mismatch(string what, result_t want, result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected char %02h last %0b empty %0b, got char %02h last %0b empty %0b",
                     $time, what, want.char_out, want.final_byte, want.field_empty,
                     got.char_out, got.final_byte, got.field_empty);
    endtask

    result_t got_res;
    result_t want_res;

    always @(posedge aclk) begin
        if (!aresetn) begin
            col_sel     = COLUMN_INDEX_RST;
            sep_len     = SEPARATOR_LENGTH_RST;
            sep_pattern = SEPARATOR_BYTES_RST;
            clear_string();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COLUMN_INDEX:     col_sel     = cfg_data[COL_W-1:0];
                    REG_SEPARATOR_LENGTH: sep_len     = cfg_data[LEN_W-1:0];
                    REG_SEPARATOR_BYTES:  sep_pattern = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) predict_extract(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                got_res = '{char_out: m_tdata, final_byte: m_tlast, field_empty: m_tuser};
                if (expected_column_bytes.size() == 0) begin
                    note_mismatch("unexpected result", '{default: 'x}, got_res);
                end else begin
                    want_res = expected_column_bytes.pop_front();
                    if (got_res.char_out !== want_res.char_out ||
                        got_res.final_byte !== want_res.final_byte ||
                        got_res.field_empty !== want_res.field_empty)
                        note_mismatch("result mismatch", want_res, got_res);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void push_char(logic [7:0] c, logic eos);
        outgoing_chars.push_back('{ch: c, eos: eos});
    endfunction

    // Field content: often a separator byte, to provoke partial and overlapping matches.
    function automatic logic [7:0] field_byte(int len);
        if ($urandom_range(0, 2) == 0)
            return sep_pattern[8*$urandom_range(0, len - 1) +: 8];
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one well-formed record; returns the number of bytes queued.
    function automatic int queue_record(int nfields, int max_field, bit trailing);
        logic [7:0] rec[$];
        int         len;
        int         w;
        len = eff_sep_len();
        for (int f = 0; f < nfields; f++) begin
            if (f > 0)
                for (int k = 0; k < len; k++) rec.push_back(sep_pattern[8*k +: 8]);
            w = $urandom_range(0, max_field);
            for (int k = 0; k < w; k++) rec.push_back(field_byte(len));
        end
        if (trailing)
            for (int k = 0; k < len; k++) rec.push_back(sep_pattern[8*k +: 8]);
        if (rec.size() == 0) rec.push_back(field_byte(len));
        foreach (rec[k]) push_char(rec[k], k == rec.size() - 1);
        return rec.size();
    endfunction

    // Queue random bytes; mark the last one as end of string if asked.
    function automatic int queue_noise(int n, bit eos);
        for (int k = 0; k < n; k++)
            push_char(8'($urandom_range(0, 255)), eos && (k == n - 1));
        return n;
    endfunction

    // Hold until every byte has transferred and every result has come back,
    // then give the block time to finish any work that makes no result.
    task automatic drain();
        while (outgoing_chars.size() != 0 || s_tvalid || expected_column_bytes.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCS) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [SEPB_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_config(logic [7:0] col, logic [3:0] len, logic [63:0] pattern);
        cfg_write(REG_COLUMN_INDEX, {56'd0, col});
        cfg_write(REG_SEPARATOR_LENGTH, {60'd0, len});
        cfg_write(REG_SEPARATOR_BYTES, pattern);
    endtask

    // Mostly well-formed records with random content, some noise strings.
    task automatic random_phase(int target);
        int queued;
        queued = 0;
        while (queued < target) begin
            if ($urandom_range(0, 4) == 0)
                queued += queue_noise($urandom_range(1, 12), 1'b1);
            else
                queued += queue_record($urandom_range(1, 6), $urandom_range(0, 4),
                                       $urandom_range(0, 3) == 0);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    int dummy;

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset config: column 1, comma separator.
        // Extreme bytes; column 1 ends early, so a closing transfer follows.
        push_char(8'h00, 1'b0);
        push_char(8'h2C, 1'b0);
        push_char(8'hFF, 1'b1);
        // Lone separator: field before it is empty.
        push_char(8'h2C, 1'b1);
        drain();

        // Trailing separator, then a column beyond the last.
        cfg_write(REG_COLUMN_INDEX, 64'd2);
        push_char(8'h78, 1'b0);
        push_char(8'h2C, 1'b1);
        push_char(8'h78, 1'b1);
        drain();

        // Column zero selects nothing.
        cfg_write(REG_COLUMN_INDEX, 64'd0);
        push_char(8'h61, 1'b0);
        push_char(8'h62, 1'b1);
        drain();

        // Length 15 saturates to an eight-byte separator.
        set_config(8'd2, 4'd15, 64'h4847_4645_4443_4241);
        for (int k = 0; k < 8; k++) push_char(8'h41 + 8'(k), 1'b0);
        push_char(8'h72, 1'b1);
        drain();

        // Length zero acts as one; separator is a zero byte.
        cfg_write(REG_SEPARATOR_LENGTH, 64'd0);
        cfg_write(REG_SEPARATOR_BYTES, 64'd0);
        push_char(8'h41, 1'b0);
        push_char(8'h00, 1'b0);
        push_char(8'h42, 1'b1);
        drain();

        // Shorten the separator mid-string: held bytes flush as plain data.
        set_config(8'd1, 4'd3, 64'h63_62_61);
        push_char(8'h78, 1'b0);
        push_char(8'h79, 1'b0);
        drain();
        cfg_write(REG_SEPARATOR_LENGTH, 64'd1);
        push_char(8'h7A, 1'b1);
        drain();

        // Random phases over a spread of settings.
        set_config(8'd1, 4'd1, 64'h2C);
        random_phase(15);
        drain();

        set_config(8'd2, 4'd2, 64'h3A3A);   // repeated bytes exercise non-overlap
        random_phase(15);
        drain();

        set_config(8'd3, 4'd3, 64'h61_62_61);
        random_phase(15);
        drain();

        set_config(8'd1, 4'd8, {$urandom, $urandom});
        random_phase(15);
        drain();

        set_config(8'd2, 4'd5, 64'hFFFF_FFFF_FFFF_FFFF);
        random_phase(15);
        drain();

        // Long receiver hold-off while bytes keep coming: the block fills up
        // and has to stall its input.
        set_config(8'd2, 4'd2, {$urandom, $urandom});
        hold_results_req = 1'b1;
        random_phase(30);
        drain();

        // Change length mid-string in both directions.
        set_config(8'd1, 4'd6, {$urandom, $urandom});
        dummy = queue_noise(5, 1'b0);
        drain();
        cfg_write(REG_SEPARATOR_LENGTH, 64'd2);
        dummy = queue_noise(3, 1'b0);
        drain();
        cfg_write(REG_SEPARATOR_LENGTH, 64'd7);
        dummy = queue_noise(4, 1'b1);
        drain();

        set_config(8'd4, 4'd4, {$urandom, $urandom});
        random_phase(15);
        drain();

        // Final stretch: full rate on both sides.
        calm = 1'b1;
        set_config(8'd2, 4'd1, 64'h2C);
        random_phase(15);
        drain();
        repeat (SETTLE_CYCS) @(posedge aclk);

        if (mismatch_count == 0 && expected_column_bytes.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Hard stop if the run hangs.
    initial begin
        #10_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/dfe_pkg.sv
hw/rtl/dfe_cell.sv
hw/rtl/dfe_out_fifo.sv
hw/rtl/delimited_field_extractor.sv
hw/rtl/dfe_checker.sv
tb/delimited_field_extractor_tb.sv
